// ----- design/hsl2rgb_pkg.sv -----
// Shared constants and pipeline control type for the HSL to RGB converter.
package hsl2rgb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_STAGES    = 6;
    localparam logic [7:0] BYTE_MAX = 8'd255;

    // One load enable per pipeline stage; a stage loads whenever it may accept an item.
    typedef struct packed {
        logic [NUM_STAGES-1:0] ld;
    } pipe_ctrl_t;

endpackage

// ----- design/hsl_to_rgb_converter.sv -----
// Top level of the HSL to RGB converter: pipeline control and channel instances.
//
// Converts one pixel per clock, while the output side does not stall, from hue,
// lightness and saturation (fixed point, FRAC_BITS fraction bits) to 8-bit red,
// green and blue, with alpha carried alongside. The pipeline has six register
// stages. The L*S multiplier sits in stage two and the three channel blend
// multipliers in stage four. Each stage holds its item while the stage after it
// is full and stalled, so bubbles are squeezed out and s_ready only falls once
// every stage holds an item.
module hsl_to_rgb_converter #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FRAC_BITS-1:0] s_hue,
    input  logic [FRAC_BITS:0]   s_lightness,
    input  logic [FRAC_BITS:0]   s_saturation,
    input  logic [7:0]           s_alpha_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_red,
    output logic [7:0]           m_green,
    output logic [7:0]           m_blue,
    output logic [7:0]           m_alpha_out
);
    import hsl2rgb_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int LW = F + 1;
    localparam int TW = F + 3;

    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    logic [NUM_STAGES-1:0] rdy;
    pipe_ctrl_t            ctrl;
    logic [7:0]            alpha_reg [NUM_STAGES];

    logic [LW-1:0] p_val, d_val;
    logic [TW-1:0] t6_red, t6_green, t6_blue;

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb begin
        rdy[NUM_STAGES-1] = ~vld_reg[NUM_STAGES-1] | m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            rdy[k] = ~vld_reg[k] | rdy[k+1];
        end
        ctrl.ld = rdy;
    end

    always_comb begin
        vld_next = vld_reg;
        if (rdy[0]) begin
            vld_next[0] = s_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (rdy[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld[0]) begin
            alpha_reg[0] <= s_alpha_in;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (ctrl.ld[k]) begin
                alpha_reg[k] <= alpha_reg[k-1];
            end
        end
    end

    hsl2rgb_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .hue        (s_hue),
        .lightness  (s_lightness),
        .saturation (s_saturation),
        .p_out      (p_val),
        .d_out      (d_val),
        .t6_red     (t6_red),
        .t6_green   (t6_green),
        .t6_blue    (t6_blue)
    );

    hsl2rgb_chan #(
        .FRAC_BITS (FRAC_BITS)
    ) u_chan_red (
        .aclk (aclk),
        .ctrl (ctrl),
        .t6   (t6_red),
        .p_in (p_val),
        .d_in (d_val),
        .chan (m_red)
    );

    hsl2rgb_chan #(
        .FRAC_BITS (FRAC_BITS)
    ) u_chan_green (
        .aclk (aclk),
        .ctrl (ctrl),
        .t6   (t6_green),
        .p_in (p_val),
        .d_in (d_val),
        .chan (m_green)
    );

    hsl2rgb_chan #(
        .FRAC_BITS (FRAC_BITS)
    ) u_chan_blue (
        .aclk (aclk),
        .ctrl (ctrl),
        .t6   (t6_blue),
        .p_in (p_val),
        .d_in (d_val),
        .chan (m_blue)
    );

    assign s_ready     = rdy[0];
    assign m_valid     = vld_reg[NUM_STAGES-1];
    assign m_alpha_out = alpha_reg[NUM_STAGES-1];

endmodule

// ----- design/hsl2rgb_prep.sv -----
// Input saturation, chroma product, hue positions, and the shared p and q-p terms.
module hsl2rgb_prep #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  hsl2rgb_pkg::pipe_ctrl_t ctrl,
    input  logic [FRAC_BITS-1:0]   hue,
    input  logic [FRAC_BITS:0]     lightness,
    input  logic [FRAC_BITS:0]     saturation,
    output logic [FRAC_BITS:0]     p_out,
    output logic [FRAC_BITS:0]     d_out,
    output logic [FRAC_BITS+2:0]   t6_red,
    output logic [FRAC_BITS+2:0]   t6_green,
    output logic [FRAC_BITS+2:0]   t6_blue
);
    import hsl2rgb_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int LW = F + 1;
    localparam int TW = F + 3;
    localparam int XW = F + 4;
    localparam int PW = 2 * F + 2;
    localparam int QW = F + 3;

    localparam logic [LW-1:0] ONE      = LW'(1) << F;
    localparam logic [XW-1:0] TWO_ONE  = XW'(2) << F;
    localparam logic [XW-1:0] FOUR_ONE = XW'(4) << F;
    localparam logic [XW-1:0] SIX_ONE  = XW'(6) << F;
    localparam logic [PW-1:0] ROUND_UP = PW'(ONE) - PW'(1);

    logic [F-1:0]  h1_reg;
    logic [LW-1:0] l1_reg, s1_reg;
    logic [LW-1:0] l_next, s_next;

    logic [PW-1:0] ls_reg, ls_next;
    logic [LW-1:0] l2_reg, s2_reg;
    logic [TW-1:0] t6r_reg, t6g_reg, t6b_reg;
    logic [TW-1:0] t6r_next, t6g_next, t6b_next;
    logic [XW-1:0] h6, sum_r, sum_b;

    logic [LW-1:0] p_reg, d_reg, p_next, d_next;
    logic [QW-1:0] lo_part, hi_part, q_full, p_full;
    logic [LW-1:0] q_val, p_val;
    logic          half;

    // Stage 1: values above one saturate to one.
    always_comb begin
        l_next = (lightness > ONE) ? ONE : lightness;
        s_next = (saturation > ONE) ? ONE : saturation;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld[0]) begin
            h1_reg <= hue;
            l1_reg <= l_next;
            s1_reg <= s_next;
        end
    end

    // Stage 2: L*S, and hue positions in sixths of a turn for each channel.
    always_comb begin
        ls_next  = PW'(l1_reg) * PW'(s1_reg);
        h6       = (XW'(h1_reg) << 2) + (XW'(h1_reg) << 1);
        sum_r    = h6 + TWO_ONE;
        sum_b    = h6 + FOUR_ONE;
        t6r_next = (sum_r >= SIX_ONE) ? TW'(sum_r - SIX_ONE) : TW'(sum_r);
        t6g_next = TW'(h6);
        t6b_next = (sum_b >= SIX_ONE) ? TW'(sum_b - SIX_ONE) : TW'(sum_b);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld[1]) begin
            ls_reg  <= ls_next;
            l2_reg  <= l1_reg;
            s2_reg  <= s1_reg;
            t6r_reg <= t6r_next;
            t6g_reg <= t6g_next;
            t6b_reg <= t6b_next;
        end
    end

    // Stage 3: q is the floored upper term. For the bright half the product is
    // subtracted, so its fraction rounds up before it is taken away.
    always_comb begin
        half    = ~l2_reg[F] & ~l2_reg[F-1];
        lo_part = QW'(ls_reg >> F);
        hi_part = QW'((ls_reg + ROUND_UP) >> F);
        q_full  = half ? (QW'(l2_reg) + lo_part)
                       : (QW'(l2_reg) + QW'(s2_reg) - hi_part);
        q_val   = q_full[LW-1:0];
        p_full  = (QW'(l2_reg) << 1) - QW'(q_val);
        p_val   = p_full[LW-1:0];
        if (s2_reg == '0) begin
            // Grey: every channel becomes L*ONE, which the channel path scales by 255.
            p_next = l2_reg;
            d_next = '0;
        end else begin
            p_next = p_val;
            d_next = q_val - p_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld[2]) begin
            p_reg <= p_next;
            d_reg <= d_next;
        end
    end

    assign p_out    = p_reg;
    assign d_out    = d_reg;
    assign t6_red   = t6r_reg;
    assign t6_green = t6g_reg;
    assign t6_blue  = t6b_reg;

endmodule

// ----- design/hsl2rgb_chan.sv -----
// One colour channel: hue segment weight, blend product and scaling to a byte.
module hsl2rgb_chan #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  hsl2rgb_pkg::pipe_ctrl_t ctrl,
    input  logic [FRAC_BITS+2:0]   t6,
    input  logic [FRAC_BITS:0]     p_in,
    input  logic [FRAC_BITS:0]     d_in,
    output logic [7:0]             chan
);
    import hsl2rgb_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int LW = F + 1;
    localparam int TW = F + 3;
    localparam int PW = 2 * F + 2;
    localparam int WW = PW + 8;

    localparam logic [TW-1:0] ONE_T   = TW'(1) << F;
    localparam logic [TW-1:0] THREE_T = TW'(3) << F;
    localparam logic [TW-1:0] FOUR_T  = TW'(4) << F;

    logic [LW-1:0] m_reg, m_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [LW-1:0] p4_reg;
    logic [PW-1:0] v_reg, v_next;
    logic [WW-1:0] w;
    logic [9:0]    scaled;
    logic [7:0]    chan_reg, chan_next;

    // Stage 3: the channel value is p*ONE + (q-p)*m, with m running from 0 to ONE.
    always_comb begin
        if (t6 < ONE_T) begin
            m_next = LW'(t6);
        end else if (t6 < THREE_T) begin
            m_next = LW'(ONE_T);
        end else if (t6 < FOUR_T) begin
            m_next = LW'(FOUR_T - t6);
        end else begin
            m_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld[2]) begin
            m_reg <= m_next;
        end
    end

    // Stage 4: blend product.
    assign prod_next = PW'(d_in) * PW'(m_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.ld[3]) begin
            prod_reg <= prod_next;
            p4_reg   <= p_in;
        end
    end

    // Stage 5: add the base level.
    assign v_next = (PW'(p4_reg) << F) + prod_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.ld[4]) begin
            v_reg <= v_next;
        end
    end

    // Stage 6: times 255 as a shift and subtract, then truncate and clamp.
    always_comb begin
        w         = (WW'(v_reg) << 8) - WW'(v_reg);
        scaled    = w[WW-1:2*F];
        chan_next = (scaled[9:8] != 2'b00) ? BYTE_MAX : scaled[7:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld[5]) begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

// ----- tb/sv/hsl_to_rgb_checker.sv -----
// Checker for the HSL to RGB converter: predicts each pixel and compares the output stream.
`timescale 1ns / 1ps

module hsl_to_rgb_checker #(
    parameter int FB = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  logic [FB-1:0] s_hue,
    input  logic [FB:0]   s_lightness,
    input  logic [FB:0]   s_saturation,
    input  logic [7:0]    s_alpha_in,
    input  logic          m_valid,
    input  logic          m_ready,
    input  logic [7:0]    m_red,
    input  logic [7:0]    m_green,
    input  logic [7:0]    m_blue,
    input  logic [7:0]    m_alpha_out,
    output int            mismatches,
    output int            outstanding
);
    import hsl2rgb_pkg::*;

    localparam logic [63:0] UNIT = 64'd1 << FB;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    pixel_t expected_pixels[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic logic [7:0] clamp_byte(input logic [63:0] v);
        return (v > 64'd255) ? BYTE_MAX : v[7:0];
    endfunction

    function automatic logic [63:0] wrap_turn(input logic [63:0] t6);
        return (t6 >= 6 * UNIT) ? t6 - 6 * UNIT : t6;
    endfunction

    // Hue position t6 is in sixths of a turn, scaled by UNIT.
    function automatic logic [7:0] blend_channel(input logic [63:0] p, input logic [63:0] q,
                                                 input logic [63:0] t6);
        logic [63:0] v;
        if (t6 < UNIT) begin
            v = p * UNIT + (q - p) * t6;
        end else if (t6 < 3 * UNIT) begin
            v = q * UNIT;
        end else if (t6 < 4 * UNIT) begin
            v = p * UNIT + (q - p) * (4 * UNIT - t6);
        end else begin
            v = p * UNIT;
        end
        return clamp_byte((v * 64'd255) >> (2 * FB));
    endfunction

    function automatic pixel_t convert_pixel(input logic [FB-1:0] hue, input logic [FB:0] l_raw,
                                             input logic [FB:0] s_raw, input logic [7:0] alpha);
        logic [63:0] l, s, q2, q, p, h6;
        pixel_t      px;
        l = (64'(l_raw) > UNIT) ? UNIT : 64'(l_raw);
        s = (64'(s_raw) > UNIT) ? UNIT : 64'(s_raw);
        px.alpha = alpha;
        if (s == 64'd0) begin
            px.red   = clamp_byte((l * 64'd255) >> FB);
            px.green = px.red;
            px.blue  = px.red;
        end else begin
            if (2 * l < UNIT) begin
                q2 = l * (UNIT + s);
            end else begin
                q2 = (l + s) * UNIT - l * s;
            end
            q  = q2 >> FB;
            p  = 2 * l - q;
            h6 = 6 * 64'(hue);
            px.red   = blend_channel(p, q, wrap_turn(h6 + 2 * UNIT));
            px.green = blend_channel(p, q, h6);
            px.blue  = blend_channel(p, q, wrap_turn(h6 + 4 * UNIT));
        end
        return px;
    endfunction

    always @(posedge aclk) begin
        pixel_t want;
        int     bad;
        bad = 0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_pixels.push_back(convert_pixel(s_hue, s_lightness, s_saturation,
                                                        s_alpha_in));
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("output item with no input item waiting for it");
                    bad++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, m_red);
                        bad++;
                    end
                    if (m_green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, m_green);
                        bad++;
                    end
                    if (m_blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, m_blue);
                        bad++;
                    end
                    if (m_alpha_out !== want.alpha) begin
                        $error("alpha_out: expected %0d, got %0d", want.alpha, m_alpha_out);
                        bad++;
                    end
                end
            end
        end
        mismatches  <= mismatches + bad;
        outstanding <= expected_pixels.size();
    end

endmodule

// ----- tb/sv/tb_hsl_to_rgb_converter.sv -----
// Top of the HSL to RGB converter testbench: clock, reset, pixel stimulus and verdict.
`timescale 1ns / 1ps

module tb_hsl_to_rgb_converter;
    import hsl2rgb_pkg::*;

    localparam int FB          = FRAC_BITS_DEF;
    localparam int UNIT        = 1 << FB;
    localparam int STALL_LIMIT = 2000;
    localparam int NUM_RANDOM  = 530;

    logic          aclk         = 1'b0;
    logic          aresetn      = 1'b0;
    logic          s_valid      = 1'b0;
    logic          s_ready;
    logic [FB-1:0] s_hue        = '0;
    logic [FB:0]   s_lightness  = '0;
    logic [FB:0]   s_saturation = '0;
    logic [7:0]    s_alpha_in   = '0;
    logic          m_valid;
    logic          m_ready      = 1'b0;
    logic [7:0]    m_red;
    logic [7:0]    m_green;
    logic [7:0]    m_blue;
    logic [7:0]    m_alpha_out;

    int mismatches;
    int outstanding;
    int idle_pct   = 26;
    int idle_count = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    hsl_to_rgb_converter #(
        .FRAC_BITS(FB)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_hue       (s_hue),
        .s_lightness (s_lightness),
        .s_saturation(s_saturation),
        .s_alpha_in  (s_alpha_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue),
        .m_alpha_out (m_alpha_out)
    );

    hsl_to_rgb_checker #(
        .FB(FB)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_hue       (s_hue),
        .s_lightness (s_lightness),
        .s_saturation(s_saturation),
        .s_alpha_in  (s_alpha_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue),
        .m_alpha_out (m_alpha_out),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= idle_pct);
    end

    // The run is abandoned once nothing has moved on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count == STALL_LIMIT) begin
                $display("hsl_to_rgb_converter regression: fail");
                $finish;
            end
        end
    end

    // Called just after a rising edge; returns just after the edge that accepts the item.
    task automatic send_pixel(input int hue, input int lt, input int st, input int alpha);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_hue        <= hue[FB-1:0];
        s_lightness  <= lt[FB:0];
        s_saturation <= st[FB:0];
        s_alpha_in   <= alpha[7:0];
        do @(posedge aclk); while (!s_ready);
    endtask

    // Mostly in range, with zero, one and values above one turning up often.
    function automatic int pick_fraction();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8) begin
            return 0;
        end else if (sel < 16) begin
            return UNIT;
        end else if (sel < 22) begin
            return $urandom_range(2 * UNIT - 1, UNIT + 1);
        end else begin
            return $urandom_range(UNIT - 1);
        end
    endfunction

    function automatic int pick_hue();
        if ($urandom_range(99) < 15) begin
            return ($urandom_range(5) * UNIT) / 6 + $urandom_range(2);
        end
        return $urandom_range(UNIT - 1);
    endfunction

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Corners of every field, grey pixels and the over-range clamps.
        send_pixel(0, 0, 0, 0);
        send_pixel(UNIT - 1, UNIT, UNIT, 255);
        send_pixel(12345, UNIT / 2, 0, 8'h55);
        send_pixel(40000, UNIT, 0, 8'hAA);
        send_pixel(777, 1, 0, 1);
        send_pixel(0, 2 * UNIT - 1, 2 * UNIT - 1, 128);
        send_pixel(30000, UNIT + 1, 0, 7);
        send_pixel(50000, UNIT / 2, UNIT + 1, 200);
        send_pixel(0, UNIT / 2 - 1, UNIT, 3);
        send_pixel(0, UNIT / 2, 1, 4);
        // Hues either side of each sixth of a turn, at full saturation.
        send_pixel(10922, UNIT / 2, UNIT, 10);
        send_pixel(10923, UNIT / 2, UNIT, 11);
        send_pixel(21845, UNIT / 2, UNIT, 12);
        send_pixel(21846, UNIT / 2, UNIT, 13);
        send_pixel(32767, UNIT / 2, UNIT, 14);
        send_pixel(32768, UNIT / 2, UNIT, 15);
        send_pixel(43690, UNIT / 2, UNIT, 16);
        send_pixel(43691, UNIT / 2, UNIT, 17);
        send_pixel(54613, UNIT / 2, UNIT, 18);
        send_pixel(54614, UNIT / 2, UNIT, 19);
        send_pixel(UNIT - 1, UNIT / 4, UNIT / 3, 254);
        send_pixel(UNIT / 12, 3 * UNIT / 4, UNIT / 2, 100);
        send_pixel(5 * UNIT / 12, UNIT - 1, UNIT - 1, 60);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            // A stretch in the middle runs with both sides flat out.
            if (n == 180) begin
                idle_pct <= 0;
            end else if (n == 310) begin
                idle_pct <= 26;
            end
            send_pixel(pick_hue(), pick_fraction(), pick_fraction(), $urandom_range(255));
        end
        s_valid <= 1'b0;

        // The count seen here is registered, so let it take in the last item first.
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (2 * NUM_STAGES + 4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("hsl_to_rgb_converter regression: pass");
        end else begin
            $display("hsl_to_rgb_converter regression: fail");
        end
        $finish;
    end

endmodule

// ----- hsl_to_rgb_converter.f -----
design/hsl2rgb_pkg.sv
design/hsl2rgb_prep.sv
design/hsl2rgb_chan.sv
design/hsl_to_rgb_converter.sv
tb/sv/hsl_to_rgb_checker.sv
tb/sv/tb_hsl_to_rgb_converter.sv
